FILE: sv/fdst_pkg.sv
// Shared types and constants of the per-flow delay statistics table.
// No dependencies; fdst_keys, fdst_update and the top level import this package.
package fdst_pkg;

   localparam int FLOW_ENTRIES_DEFAULT = 16;

   localparam logic CMD_LOG  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
   localparam logic [47:0] SUM_MAX   = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic        command;
      logic [7:0]  host_id;
      logic [15:0] flow_id;
      logic [31:0] tx_tick;
      logic [31:0] now_tick;
      logic [3:0]  read_index;
   } fdst_req_type;

   typedef struct packed {
      logic [3:0]  entry_index;
      logic        new_flow;
      logic        table_full;
      logic        entry_valid;
      logic [7:0]  entry_sender;
      logic [15:0] entry_flow;
      logic [31:0] start_tick;
      logic [31:0] end_tick;
      logic [31:0] packet_count;
      logic [47:0] delay_sum;
   } fdst_rsp_type;

   // One word of the statistics memory.
   typedef struct packed {
      logic [7:0]  sender;
      logic [15:0] flow;
      logic [31:0] first_tick;
      logic [31:0] last_tick;
      logic [31:0] pkt_total;
      logic [47:0] delay_total;
   } fdst_stats_type;

   // Outcome of one key lookup.
   typedef struct packed {
      logic hit;
      logic free_found;
      logic read_used;
   } fdst_lookup_type;

   // Claim of a free entry by a new flow.
   typedef struct packed {
      logic        new_entry;
      logic [7:0]  sender;
      logic [15:0] flow;
   } fdst_key_write_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_SELECT,
      S_MODIFY
   } fdst_state_type;

endpackage

FILE: sv/fdst_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module fdst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/fdst_keys.sv
// Key store of the flow table: used bits, flow keys and the parallel match.
// Depends on fdst_pkg.
module fdst_keys #(
   parameter int FLOW_ENTRIES = fdst_pkg::FLOW_ENTRIES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            lookup_en,
   input  logic [7:0]                      host_id,
   input  logic [15:0]                     flow_id,
   input  logic [$clog2(FLOW_ENTRIES)-1:0] read_addr,
   input  fdst_pkg::fdst_key_write_type    key_write,
   input  logic [$clog2(FLOW_ENTRIES)-1:0] key_write_idx,
   output fdst_pkg::fdst_lookup_type       lookup,
   output logic [$clog2(FLOW_ENTRIES)-1:0] hit_idx,
   output logic [$clog2(FLOW_ENTRIES)-1:0] free_idx
);
   import fdst_pkg::*;

   localparam int IDX_W = $clog2(FLOW_ENTRIES);

   logic [FLOW_ENTRIES-1:0] used_ff;
   logic [FLOW_ENTRIES-1:0] used_in;
   logic [23:0]             key_ff [FLOW_ENTRIES];
   logic [FLOW_ENTRIES-1:0] match_ff;
   logic [FLOW_ENTRIES-1:0] match_in;
   logic [FLOW_ENTRIES-1:0] free_ff;
   logic                    read_used_ff;

   always_comb begin
      used_in = used_ff;
      if (key_write.new_entry) begin
         used_in[key_write_idx] = 1'b1;
      end
   end

   // Each entry compares its own key against the item's key.
   always_comb begin
      for (int i = 0; i < FLOW_ENTRIES; i++) begin
         match_in[i] = used_ff[i] && (key_ff[i] == {host_id, flow_id});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         match_ff     <= '0;
         free_ff      <= '0;
         read_used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         if (lookup_en) begin
            match_ff     <= match_in;
            free_ff      <= ~used_ff;
            read_used_ff <= used_ff[read_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (key_write.new_entry) begin
         key_ff[key_write_idx] <= {key_write.sender, key_write.flow};
      end
   end

   // Lowest-numbered match and lowest-numbered free entry.
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = FLOW_ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (free_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign lookup.hit        = |match_ff;
   assign lookup.free_found = |free_ff;
   assign lookup.read_used  = read_used_ff;

   a_keys_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_ff))
      else $error("a key matched more than one entry");

   a_claim_free: assert property (@(posedge clock) disable iff (reset)
      key_write.new_entry |-> !used_ff[key_write_idx])
      else $error("a new flow claimed an entry already in use");

   a_claim_no_hit: assert property (@(posedge clock) disable iff (reset)
      key_write.new_entry |-> (lookup.free_found && !lookup.hit))
      else $error("a new flow was created although its key matched or no entry was free");

endmodule

FILE: sv/fdst_update.sv
// Statistics update for one logged packet: count, saturating delay sum, ticks.
// Depends on fdst_pkg.
module fdst_update (
   input  fdst_pkg::fdst_stats_type old_stats,
   input  fdst_pkg::fdst_req_type   req,
   input  logic                     is_new,
   output fdst_pkg::fdst_stats_type new_stats
);
   import fdst_pkg::*;

   logic [31:0] delay;
   logic [48:0] sum_wide;
   logic [31:0] count_base;
   logic [47:0] sum_base;

   always_comb begin
      // A packet sent after it arrived counts as zero delay.
      delay = (req.now_tick >= req.tx_tick) ? (req.now_tick - req.tx_tick) : '0;

      count_base = is_new ? '0 : old_stats.pkt_total;
      sum_base   = is_new ? '0 : old_stats.delay_total;
      sum_wide   = {1'b0, sum_base} + {17'd0, delay};

      new_stats.sender     = is_new ? req.host_id : old_stats.sender;
      new_stats.flow       = is_new ? req.flow_id : old_stats.flow;
      new_stats.first_tick = is_new ? req.now_tick : old_stats.first_tick;
      new_stats.last_tick  = req.now_tick;
      new_stats.pkt_total  = (count_base == COUNT_MAX) ? COUNT_MAX : count_base + 32'd1;
      new_stats.delay_total = sum_wide[48] ? SUM_MAX : sum_wide[47:0];
   end

endmodule

FILE: sv/per_flow_delay_stats_table_unit.sv
// Top level of the per-flow delay statistics table: sequencer, response register.
// Depends on fdst_pkg, fdst_ram, fdst_keys and fdst_update.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  fdst_req_type (log or read command)
//   rsp_      out        rsp_valid / rsp_ready  fdst_rsp_type (one result per item)
//
// Each item passes through acceptance, key match (registered), entry
// selection with the statistics memory read, and modify with write-back.
// The registered match and the registered memory read lie ahead of the
// read-modify-write. A new item is taken only after the last one has left
// the modify step. Reset clears the used bits and the sequencer; no
// clearing pass is needed. A stalled response holds the block in the modify
// step, but an item may be accepted while a finished result still waits.
module per_flow_delay_stats_table_unit #(
   parameter int FLOW_ENTRIES = fdst_pkg::FLOW_ENTRIES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fdst_pkg::fdst_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fdst_pkg::fdst_rsp_type rsp_payload
);
   import fdst_pkg::*;

   localparam int IDX_W = $clog2(FLOW_ENTRIES);

   fdst_state_type     state_ff;
   fdst_state_type     state_in;

   fdst_req_type       req_ff;
   fdst_rsp_type       rsp_ff;
   fdst_rsp_type       rsp_in;
   logic               rsp_valid_ff;

   // Outcome of the selection step, held through the modify step.
   logic [IDX_W-1:0]   sel_idx_ff;
   logic [IDX_W-1:0]   sel_idx_in;
   logic               sel_new_ff;
   logic               sel_new_in;
   logic               sel_full_ff;
   logic               sel_full_in;
   logic               sel_valid_ff;
   logic               sel_valid_in;

   logic               req_take;
   logic               lookup_en;
   logic               ram_rd_en;
   logic               rsp_load;
   logic               ram_we;
   logic               is_read;
   logic               read_in_range;
   logic [IDX_W+3:0]   read_idx_wide;
   logic [IDX_W+3:0]   sel_idx_wide;

   fdst_lookup_type    lookup;
   logic [IDX_W-1:0]   hit_idx;
   logic [IDX_W-1:0]   free_idx;
   fdst_key_write_type key_write;
   fdst_stats_type     ram_rd_data;
   fdst_stats_type     upd_stats;

   assign is_read       = (req_ff.command == CMD_READ);
   assign read_idx_wide = (IDX_W + 4)'(req_ff.read_index);
   assign read_in_range = ((IDX_W + 5)'(req_ff.read_index) < (IDX_W + 5)'(FLOW_ENTRIES));
   assign sel_idx_wide  = (IDX_W + 4)'(sel_idx_ff);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = S_SELECT;
         end
         S_SELECT: begin
            state_in = S_MODIFY;
         end
         S_MODIFY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      lookup_en = 1'b0;
      ram_rd_en = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_LOOKUP: begin
            lookup_en = 1'b1;
         end
         S_SELECT: begin
            ram_rd_en = 1'b1;
         end
         S_MODIFY: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign req_take = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_payload;
      end
   end

   // ------------------------------------------------------------ key lookup
   // The item's key was captured at acceptance; the match is registered in
   // the key store during the lookup step.
   fdst_keys #(
      .FLOW_ENTRIES (FLOW_ENTRIES)
   ) u_keys (
      .clock         (clock),
      .reset         (reset),
      .lookup_en     (lookup_en),
      .host_id       (req_ff.host_id),
      .flow_id       (req_ff.flow_id),
      .read_addr     (read_idx_wide[IDX_W-1:0]),
      .key_write     (key_write),
      .key_write_idx (sel_idx_ff),
      .lookup        (lookup),
      .hit_idx       (hit_idx),
      .free_idx      (free_idx)
   );

   // ------------------------------------------------------------- selection
   // A read names its entry directly. A log takes its matching entry, else
   // the lowest free one; with neither the packet is dropped.
   always_comb begin
      sel_idx_in   = '0;
      sel_new_in   = 1'b0;
      sel_full_in  = 1'b0;
      sel_valid_in = 1'b0;
      priority if (is_read) begin
         sel_idx_in   = read_idx_wide[IDX_W-1:0];
         sel_valid_in = read_in_range && lookup.read_used;
      end else if (lookup.hit) begin
         sel_idx_in   = hit_idx;
         sel_valid_in = 1'b1;
      end else if (lookup.free_found) begin
         sel_idx_in   = free_idx;
         sel_new_in   = 1'b1;
         sel_valid_in = 1'b1;
      end else begin
         sel_full_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_rd_en) begin
         sel_idx_ff   <= sel_idx_in;
         sel_new_ff   <= sel_new_in;
         sel_full_ff  <= sel_full_in;
         sel_valid_ff <= sel_valid_in;
      end
   end

   // ------------------------------------------------------ statistics memory
   // Only one item is in flight, so the write-back of one item is complete
   // before the next item reads the memory; no forwarding is needed.
   fdst_ram #(
      .WIDTH ($bits(fdst_stats_type)),
      .DEPTH (FLOW_ENTRIES)
   ) u_stats_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (sel_idx_ff),
      .wr_data (upd_stats),
      .rd_en   (ram_rd_en),
      .rd_addr (sel_idx_in),
      .rd_data (ram_rd_data)
   );

   fdst_update u_update (
      .old_stats (ram_rd_data),
      .req       (req_ff),
      .is_new    (sel_new_ff),
      .new_stats (upd_stats)
   );

   assign ram_we                = rsp_load && !is_read && !sel_full_ff;
   assign key_write.new_entry   = ram_we && sel_new_ff;
   assign key_write.sender      = req_ff.host_id;
   assign key_write.flow        = req_ff.flow_id;

   // ------------------------------------------------------- response register
   always_comb begin
      rsp_in = '0;
      priority if (is_read) begin
         rsp_in.entry_index = req_ff.read_index;
         if (sel_valid_ff) begin
            rsp_in.entry_valid  = 1'b1;
            rsp_in.entry_sender = ram_rd_data.sender;
            rsp_in.entry_flow   = ram_rd_data.flow;
            rsp_in.start_tick   = ram_rd_data.first_tick;
            rsp_in.end_tick     = ram_rd_data.last_tick;
            rsp_in.packet_count = ram_rd_data.pkt_total;
            rsp_in.delay_sum    = ram_rd_data.delay_total;
         end
      end else if (sel_full_ff) begin
         // A dropped packet reports nothing but the full flag.
         rsp_in.table_full = 1'b1;
      end else begin
         rsp_in.entry_index  = sel_idx_wide[3:0];
         rsp_in.new_flow     = sel_new_ff;
         rsp_in.entry_valid  = 1'b1;
         rsp_in.entry_sender = upd_stats.sender;
         rsp_in.entry_flow   = upd_stats.flow;
         rsp_in.start_tick   = upd_stats.first_tick;
         rsp_in.end_tick     = upd_stats.last_tick;
         rsp_in.packet_count = upd_stats.pkt_total;
         rsp_in.delay_sum    = upd_stats.delay_total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------------------------------------------------------- checks
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.table_full) |-> (!rsp_ff.new_flow && !rsp_ff.entry_valid))
      else $error("a dropped packet reported an entry");

   a_write_ends_item: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("a write-back did not finish its item");

   a_accept_starts_lookup: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_LOOKUP))
      else $error("an accepted item did not start a lookup");

endmodule
